// ===== src/rspc_pkg.sv =====
package rspc_pkg;

  // Screen geometry (square screen, pixels)
  localparam int SCREEN_SIZE = 480;
  localparam logic [31:0] HALF_SCREEN = 32'(SCREEN_SIZE / 2);
  localparam logic signed [15:0] SCREEN_LIMIT = 16'(SCREEN_SIZE);

  // Field widths
  localparam int TILE_W  = 14;
  localparam int POS_W   = 16;
  localparam int VIEW_W  = 30;
  localparam int ZOOM_W  = 5;
  localparam int STYLE_W = 8;
  localparam int COORD_W = 16;
  localparam int LWID_W  = 4;
  localparam int COLOR_W = 16;

  // Packed channel widths, padded to whole bytes
  localparam int IN_BITS   = 2 * TILE_W + 4 * POS_W + STYLE_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 1 + 4 * COORD_W + LWID_W + COLOR_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM   = 2'd2;

  // Zoom limits and the reset zoom
  localparam logic [ZOOM_W-1:0] ZOOM_MIN   = 5'd13;
  localparam logic [ZOOM_W-1:0] ZOOM_MAX   = 5'd17;
  localparam logic [ZOOM_W-1:0] ZOOM_RESET = 5'd15;
  localparam logic [ZOOM_W-1:0] ZOOM_BASE  = 5'd22;

  // Road styles
  localparam logic [STYLE_W-1:0] STYLE_MINOR   = 8'd0;
  localparam logic [STYLE_W-1:0] STYLE_MAJOR   = 8'd1;
  localparam logic [STYLE_W-1:0] STYLE_SPECIAL = 8'd2;

  // Widths in quarter pixels
  localparam logic [LWID_W-1:0] WIDTH_MAJOR = 4'd8;
  localparam logic [LWID_W-1:0] WIDTH_MINOR = 4'd6;
  localparam logic [LWID_W-1:0] WIDTH_THIN  = 4'd4;

  // RGB565 colors
  localparam logic [COLOR_W-1:0] COLOR_SPECIAL = 16'h35AD;
  localparam logic [COLOR_W-1:0] COLOR_MAJOR   = 16'h8410;
  localparam logic [COLOR_W-1:0] COLOR_OTHER   = 16'h4208;

  typedef struct packed {
    logic [STYLE_W-1:0] road_style;
    logic [POS_W-1:0]   end_y;
    logic [POS_W-1:0]   end_x;
    logic [POS_W-1:0]   start_y;
    logic [POS_W-1:0]   start_x;
    logic [TILE_W-1:0]  tile_row;
    logic [TILE_W-1:0]  tile_col;
  } seg_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0]        line_color;
    logic [LWID_W-1:0]         line_width;
    logic signed [COORD_W-1:0] screen_by;
    logic signed [COORD_W-1:0] screen_bx;
    logic signed [COORD_W-1:0] screen_ay;
    logic signed [COORD_W-1:0] screen_ax;
    logic                      visible;
  } seg_out_t;

  // One axis: world - view + (half screen << k), scaled down by 2^k with
  // truncation toward zero, saturated to 16 bits.
  function automatic logic signed [COORD_W-1:0] project_axis(
    input logic [TILE_W-1:0] tile,
    input logic [POS_W-1:0]  pos,
    input logic [VIEW_W-1:0] view,
    input logic [3:0]        k
  );
    logic signed [31:0] num;
    logic signed [31:0] bias;
    logic signed [31:0] q;
    logic signed [COORD_W-1:0] res;
    num  = $signed({2'b00, tile, pos}) - $signed({2'b00, view})
           + $signed(HALF_SCREEN << k);
    // Negative values get 2^k-1 added so the arithmetic shift rounds to zero
    bias = num[31] ? $signed((32'd1 << k) - 32'd1) : 32'sd0;
    q    = (num + bias) >>> k;
    if (q > 32'sd32767) begin
      res = 16'sh7FFF;
    end else if (q < -32'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = q[COORD_W-1:0];
    end
    return res;
  endfunction

  // True when the span [min(a,b), max(a,b)] lies wholly off screen
  function automatic logic span_misses(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic below;
    logic above;
    below = a[COORD_W-1] && b[COORD_W-1];
    above = (a >= SCREEN_LIMIT) && (b >= SCREEN_LIMIT);
    return below || above;
  endfunction

endpackage

// ===== src/road_segment_project_cull_top.sv =====
// Channel  | Dir | Signals                      | Item
// ---------+-----+------------------------------+-------------------------------------
// s_       | in  | s_tvalid s_tready s_tdata    | one road segment (tiles, endpoints, style)
// m_       | out | m_tvalid m_tready m_tdata    | projected endpoints, visible, width, color
// cfg_     | in  | cfg_we cfg_index cfg_data    | view_x (0), view_y (1), zoom_level (2)
//
// Two-register pipeline: an input register, then one pass of adds, a shift
// and compares, then the result register. Throughput is one item per cycle
// unless m_tready stalls. Either register advances when the one after it is empty
// or being drained, so an m_tready stall backs up through s_tready without loss.
// rst is synchronous and clears both valid bits and the config registers
// (view 0, zoom 15).
module road_segment_project_cull_top
  import rspc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // [13:0] tile_col, [27:14] tile_row, [43:28] start_x, [59:44] start_y,
  // [75:60] end_x, [91:76] end_y, [99:92] road_style, [103:100] zero
  input  logic [IN_DATA_W-1:0]      s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [0] visible, [16:1] screen_ax, [32:17] screen_ay, [48:33] screen_bx,
  // [64:49] screen_by, [68:65] line_width, [84:69] line_color, [87:85] zero
  output logic [OUT_DATA_W-1:0]     m_tdata,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [VIEW_W-1:0]         cfg_data
);

  // Configuration
  logic [VIEW_W-1:0] view_x;
  logic [VIEW_W-1:0] view_y;
  logic [ZOOM_W-1:0] zoom_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_x     <= '0;
      view_y     <= '0;
      zoom_level <= ZOOM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VIEW_X: view_x     <= cfg_data;
        CFG_VIEW_Y: view_y     <= cfg_data;
        CFG_ZOOM:   zoom_level <= cfg_data[ZOOM_W-1:0];
        default:    ;
      endcase
    end
  end

  // Pipeline control
  logic     in_valid;
  seg_in_t  in_seg;
  logic     out_valid;
  seg_out_t out_seg;
  logic     out_load;
  logic     in_load;

  assign out_load = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || out_load;
  assign in_load  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= 1'b1;
    end else if (out_load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_seg <= seg_in_t'(s_tdata[IN_BITS-1:0]);
    end
  end

  // Projection and cull
  logic [ZOOM_W-1:0] zoom_clamped;
  logic [ZOOM_W-1:0] shift_wide;
  logic [3:0]        shift_k;
  seg_out_t          res;

  always_comb begin
    if (zoom_level < ZOOM_MIN) begin
      zoom_clamped = ZOOM_MIN;
    end else if (zoom_level > ZOOM_MAX) begin
      zoom_clamped = ZOOM_MAX;
    end else begin
      zoom_clamped = zoom_level;
    end
    shift_wide = ZOOM_BASE - zoom_clamped;   // 5..9
    shift_k    = shift_wide[3:0];

    res.screen_ax = project_axis(in_seg.tile_col, in_seg.start_x, view_x, shift_k);
    res.screen_ay = project_axis(in_seg.tile_row, in_seg.start_y, view_y, shift_k);
    res.screen_bx = project_axis(in_seg.tile_col, in_seg.end_x, view_x, shift_k);
    res.screen_by = project_axis(in_seg.tile_row, in_seg.end_y, view_y, shift_k);
    res.visible   = !(span_misses(res.screen_ax, res.screen_bx) ||
                      span_misses(res.screen_ay, res.screen_by));

    // Zoom 13 draws every road thin
    if (zoom_clamped == ZOOM_MIN) begin
      res.line_width = WIDTH_THIN;
    end else if (in_seg.road_style == STYLE_MAJOR) begin
      res.line_width = WIDTH_MAJOR;
    end else if (in_seg.road_style == STYLE_MINOR) begin
      res.line_width = WIDTH_MINOR;
    end else begin
      res.line_width = WIDTH_THIN;
    end

    if (in_seg.road_style == STYLE_SPECIAL) begin
      res.line_color = COLOR_SPECIAL;
    end else if (in_seg.road_style == STYLE_MAJOR) begin
      res.line_color = COLOR_MAJOR;
    end else begin
      res.line_color = COLOR_OTHER;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_seg <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_seg};

endmodule
